// ===== rtl/core/cosine_similarity_engine_assert.svh =====
// Assertion macros for the cosine similarity engine
`ifndef COSINE_SIMILARITY_ENGINE_ASSERT_SVH
`define COSINE_SIMILARITY_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge outside reset.
`define CSE_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cosine similarity engine: assertion failed");
// Check prop at every rising edge, reset included.
`define CSE_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cosine similarity engine: reset assertion failed");
`else
`define CSE_ASSERT(label, clk, rst, prop)
`define CSE_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/core/cse_pkg.sv =====
// Constants and types shared by the cosine similarity engine
package cse_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LENGTH_BITS = 16;
  localparam int ACC_RAW     = 2 * SAMPLE_BITS + LENGTH_BITS;
  localparam int ACC_BITS    = (ACC_RAW > 62) ? 62 : ACC_RAW;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int IN_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8;

  // Shared multiplier works on halves of the accumulator magnitudes.
  localparam int HALF_BITS   = (ACC_BITS + 1) / 2;
  localparam int OP_BITS     = 2 * HALF_BITS;
  localparam int MUL_BITS    = 2 * HALF_BITS;
  localparam int SQ_BITS     = 2 * OP_BITS;

  // Result format and rounding search.
  localparam int RES_BITS    = 16;
  localparam int STEP_BITS   = $clog2(RES_BITS);
  localparam int SRCH_BITS   = SQ_BITS + 2 * RES_BITS + 3;
  localparam logic [RES_BITS-1:0] POS_CAP = RES_BITS'((2 ** (RES_BITS - 1)) - 1);
  localparam logic [RES_BITS-1:0] NEG_CAP = RES_BITS'(2 ** (RES_BITS - 1));
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(RES_BITS - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_INIT = 6'b001000,
    ST_SRCH = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

endpackage

// ===== rtl/core/cosine_similarity_engine.sv =====
// Cosine similarity engine: streaming dot/norm accumulation and a sequenced finish
//
// Each request carries one element pair and is taken while the engine is idle;
// the dot product and both squared norms are summed in saturating 48-bit
// accumulators. A request with tlast set ends the vector: the engine then drops
// tready through a prepare state, 8 partial products on one shared 24x24
// multiplier, a setup state, 16 steps of a bit-by-bit rounding search on one wide
// adder and comparator and a result load, and stays busy while the previous result
// still waits to be taken. It emits dot / sqrt(norm_a * norm_b) as Q1.15 rounded to
// nearest (ties away from zero) and saturated, and clears the sums. A zero norm skips
// the multiplier and search and gives 0 with the degenerate flag in tuser. Element
// requests are taken while a result still waits on the output side.
`include "cosine_similarity_engine_assert.svh"

module cosine_similarity_engine
  import cse_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_BITS-1:0]  s_tdata,   // a_value, b_value
  input  logic                s_tlast,   // last_element
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RES_BITS-1:0] m_tdata,   // similarity
  output logic                m_tuser    // degenerate
);

  function automatic logic signed [ACC_BITS-1:0] sat_add(
    input logic signed [ACC_BITS-1:0]  acc,
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [ACC_BITS:0] s;
    s = {acc[ACC_BITS-1], acc} + {{(ACC_BITS + 1 - PROD_BITS){p[PROD_BITS-1]}}, p};
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return {s[ACC_BITS], {(ACC_BITS - 1){~s[ACC_BITS]}}};
    end
    return s[ACC_BITS-1:0];
  endfunction

  state_t state;

  logic signed [ACC_BITS-1:0]  dot_sum, norm_a_sum, norm_b_sum;
  logic signed [ACC_BITS-1:0]  dot_next, norm_a_next, norm_b_next;
  logic signed [SAMPLE_BITS-1:0] a_in, b_in;
  logic signed [PROD_BITS-1:0] p_ab, p_aa, p_bb;

  logic [ACC_BITS-1:0]  op_d, op_na, op_nb;
  logic                 neg, degen;
  logic [2:0]           cnt;
  logic [SQ_BITS-1:0]   p_reg, d2_reg;
  logic [OP_BITS-1:0]   opx, opy;
  logic [HALF_BITS-1:0] x_half, y_half;
  logic [MUL_BITS-1:0]  prod;
  logic [1:0]           shift_sel;
  logic [SQ_BITS-1:0]   term;

  logic signed [SRCH_BITS-1:0] x_reg, ys_reg, ps_reg, trial, r_ext;
  logic                        fits;
  logic [STEP_BITS-1:0]        step;
  logic [RES_BITS-1:0]         q_reg, q_clamp, sim;

  logic in_fire, load_out;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign load_out = (state == ST_DONE) && (!m_tvalid || m_tready);

  assign a_in = s_tdata[SAMPLE_BITS-1:0];
  assign b_in = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign p_ab = a_in * b_in;
  assign p_aa = a_in * a_in;
  assign p_bb = b_in * b_in;
  assign dot_next    = sat_add(dot_sum, p_ab);
  assign norm_a_next = sat_add(norm_a_sum, p_aa);
  assign norm_b_next = sat_add(norm_b_sum, p_bb);

  // Shared multiplier: steps 0-3 form na*nb, steps 4-7 form d*d.
  assign opx    = cnt[2] ? OP_BITS'(op_d) : OP_BITS'(op_na);
  assign opy    = cnt[2] ? OP_BITS'(op_d) : OP_BITS'(op_nb);
  assign x_half = cnt[1] ? opx[OP_BITS-1:HALF_BITS] : opx[HALF_BITS-1:0];
  assign y_half = cnt[0] ? opy[OP_BITS-1:HALF_BITS] : opy[HALF_BITS-1:0];
  assign prod   = x_half * y_half;
  assign shift_sel = {1'b0, cnt[1]} + {1'b0, cnt[0]};

  always_comb begin
    case (shift_sel)
      2'd0:    term = SQ_BITS'(prod);
      2'd1:    term = SQ_BITS'(prod) << HALF_BITS;
      default: term = SQ_BITS'(prod) << (2 * HALF_BITS);
    endcase
  end

  // Trial test (2q-1)^2 * P <= 2^(2*RES_BITS) * D^2, built up incrementally.
  assign r_ext = SRCH_BITS'({d2_reg, {(2 * RES_BITS){1'b0}}});
  assign trial = x_reg + ys_reg + ps_reg;
  assign fits  = (trial <= r_ext);

  always_comb begin
    if (neg) begin
      q_clamp = (q_reg > NEG_CAP) ? NEG_CAP : q_reg;
    end else begin
      q_clamp = (q_reg > POS_CAP) ? POS_CAP : q_reg;
    end
    if (degen) begin
      sim = '0;
    end else if (neg) begin
      sim = -q_clamp;
    end else begin
      sim = q_clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (s_tlast) begin
              op_d       <= dot_next;
              op_na      <= norm_a_next;
              op_nb      <= norm_b_next;
              dot_sum    <= '0;
              norm_a_sum <= '0;
              norm_b_sum <= '0;
              state      <= ST_PREP;
            end else begin
              dot_sum    <= dot_next;
              norm_a_sum <= norm_a_next;
              norm_b_sum <= norm_b_next;
            end
          end
        end
        ST_PREP: begin
          neg    <= op_d[ACC_BITS-1];
          op_d   <= op_d[ACC_BITS-1] ? -op_d : op_d;
          p_reg  <= '0;
          d2_reg <= '0;
          cnt    <= '0;
          q_reg  <= '0;
          if (op_na == '0 || op_nb == '0) begin
            degen <= 1'b1;
            state <= ST_DONE;
          end else begin
            degen <= 1'b0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (cnt[2]) begin
            d2_reg <= d2_reg + term;
          end else begin
            p_reg <= p_reg + term;
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          x_reg  <= SRCH_BITS'(p_reg);
          ys_reg <= -(SRCH_BITS'(p_reg) << (RES_BITS + 1));
          ps_reg <= SRCH_BITS'(p_reg) << (2 * RES_BITS);
          step   <= LAST_STEP;
          state  <= ST_SRCH;
        end
        ST_SRCH: begin
          // Keep the bit if the trial still fits; slide the scaled terms down.
          if (fits) begin
            x_reg       <= trial;
            ys_reg      <= (ys_reg >>> 1) + ps_reg;
            q_reg[step] <= 1'b1;
          end else begin
            ys_reg <= ys_reg >>> 1;
          end
          ps_reg <= ps_reg >>> 2;
          step   <= step - STEP_BITS'(1);
          if (step == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= sim;
      m_tuser <= degen;
    end
  end

  `CSE_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !m_tvalid && s_tready)
  `CSE_ASSERT(a_degen_zero, clk, rst, m_tvalid && m_tuser |-> m_tdata == '0)
  `CSE_ASSERT(a_last_blocks, clk, rst, s_tvalid && s_tready && s_tlast |=> !s_tready)
  `CSE_ASSERT(a_busy_sums_clear, clk, rst, !s_tready |-> {dot_sum, norm_a_sum, norm_b_sum} == '0)
  `CSE_ASSERT(a_result_from_done, clk, rst, $rose(m_tvalid) |-> $past(state == ST_DONE))

endmodule

// ===== verif/cosine_similarity_engine_tb.sv =====
// Self-checking stream testbench for the cosine similarity engine
`timescale 1ns / 100ps

module cosine_similarity_engine_tb;
  import cse_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam longint ACC_HI     = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_LO     = -ACC_HI - 1;

  typedef enum int {
    VEC_RANDOM,
    VEC_SAME,
    VEC_OPPOSITE,
    VEC_NEAR,
    VEC_TINY,
    VEC_ZERO_A,
    VEC_ZERO_B
  } vec_kind_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] a;
    logic signed [SAMPLE_BITS-1:0] b;
    logic                          last;
  } pair_t;

  typedef struct {
    logic signed [RES_BITS-1:0] sim;
    logic                       degen;
  } score_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [IN_BITS-1:0]  s_tdata = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RES_BITS-1:0] m_tdata;
  logic                m_tuser;

  cosine_similarity_engine i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pair_t  pending_pairs[$];
  score_t expected_scores[$];

  longint dot_acc    = 0;
  longint norm_a_acc = 0;
  longint norm_b_acc = 0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int pairs_taken    = 0;
  int scores_checked = 0;
  int degen_seen     = 0;
  int mismatch_count = 0;
  int idle_cycles    = 0;
  logic req_taken    = 1'b0;

  function automatic longint sat_add(input longint acc, input longint inc);
    longint s;
    s = acc + inc;
    if (s > ACC_HI) return ACC_HI;
    if (s < ACC_LO) return ACC_LO;
    return s;
  endfunction

  // Largest q in [0, cap] with (2q-1)^2 * na * nb <= 2^32 * dot^2.
  function automatic logic [RES_BITS-1:0] rounded_cosine(input longint unsigned dmag,
                                                         input longint unsigned na,
                                                         input longint unsigned nb,
                                                         input int unsigned cap);
    logic [191:0]    norm_prod;
    logic [191:0]    dot_sq;
    logic [191:0]    trial;
    longint unsigned k;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mid;
    norm_prod = 192'(na) * 192'(nb);
    dot_sq    = (192'(dmag) * 192'(dmag)) << 32;
    lo = 0;
    hi = cap;
    while (lo < hi) begin
      mid   = (lo + hi + 1) / 2;
      k     = 2 * longint'(mid) - 1;
      trial = 192'(k * k) * norm_prod;
      if (trial <= dot_sq) lo = mid;
      else hi = mid - 1;
    end
    return RES_BITS'(lo);
  endfunction

  // Fold one element pair into the sums; on the last pair produce the score.
  function automatic logic accumulate_pair(input pair_t p, output score_t s);
    logic            neg;
    longint unsigned dmag;
    logic [RES_BITS-1:0] q;
    s.sim   = '0;
    s.degen = 1'b0;
    dot_acc    = sat_add(dot_acc, longint'(p.a) * longint'(p.b));
    norm_a_acc = sat_add(norm_a_acc, longint'(p.a) * longint'(p.a));
    norm_b_acc = sat_add(norm_b_acc, longint'(p.b) * longint'(p.b));
    if (!p.last) return 1'b0;
    if (norm_a_acc <= 0 || norm_b_acc <= 0) begin
      s.degen = 1'b1;
    end else begin
      neg  = dot_acc < 0;
      dmag = neg ? longint'(0) - dot_acc : dot_acc;
      q    = rounded_cosine(dmag, norm_a_acc, norm_b_acc, neg ? 32768 : 32767);
      s.sim = neg ? -q : q;
    end
    dot_acc    = 0;
    norm_a_acc = 0;
    norm_b_acc = 0;
    return 1'b1;
  endfunction

  // Driver: present the next request at the falling edge.
  always @(negedge clk) begin
    pair_t p;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (!s_tvalid || req_taken) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          p = pending_pairs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {p.b, p.a};
          s_tlast  <= p.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on accepted requests, check accepted results.
  always @(posedge clk) begin
    pair_t  p;
    score_t s;
    score_t want;
    req_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        p.a    = s_tdata[SAMPLE_BITS-1:0];
        p.b    = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        p.last = s_tlast;
        pairs_taken++;
        if (accumulate_pair(p, s)) expected_scores.push_back(s);
      end
      if (m_tvalid && m_tready) begin
        scores_checked++;
        if (m_tuser) degen_seen++;
        if (expected_scores.size() == 0) begin
          $error("unexpected result: similarity %0d, degenerate %0b",
                 $signed(m_tdata), m_tuser);
          mismatch_count++;
        end else begin
          want = expected_scores.pop_front();
          if (m_tdata !== want.sim) begin
            $error("similarity: expected %0d, got %0d", want.sim, $signed(m_tdata));
            mismatch_count++;
          end
          if (m_tuser !== want.degen) begin
            $error("degenerate: expected %0b, got %0b", want.degen, m_tuser);
            mismatch_count++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic void push_pair(input logic [SAMPLE_BITS-1:0] a,
                                    input logic [SAMPLE_BITS-1:0] b,
                                    input logic last);
    pair_t p;
    p.a    = a;
    p.b    = b;
    p.last = last;
    pending_pairs.push_back(p);
  endfunction

  function automatic void queue_vector(input int len, input vec_kind_t kind);
    logic [SAMPLE_BITS-1:0] a;
    logic [SAMPLE_BITS-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = SAMPLE_BITS'($urandom);
      b = SAMPLE_BITS'($urandom);
      case (kind)
        VEC_SAME:     b = a;
        VEC_OPPOSITE: b = -a;
        VEC_NEAR:     b = a + SAMPLE_BITS'($urandom_range(64)) - SAMPLE_BITS'(32);
        VEC_TINY: begin
          a = SAMPLE_BITS'($urandom_range(4)) - SAMPLE_BITS'(2);
          b = SAMPLE_BITS'($urandom_range(4)) - SAMPLE_BITS'(2);
        end
        VEC_ZERO_A:   a = '0;
        VEC_ZERO_B:   b = '0;
        default: ;
      endcase
      push_pair(a, b, i == len - 1);
    end
  endfunction

  // Hold off until every request is taken and every result has come back.
  task automatic drain_all();
    while (pending_pairs.size() != 0 || s_tvalid || expected_scores.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_phase(input int send_idle, input int recv_stall, input int target);
    int        stop_at;
    int        len;
    vec_kind_t kind;
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    stop_at = pending_pairs.size() + target;
    while (pending_pairs.size() < stop_at) begin
      len  = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      kind = vec_kind_t'($urandom_range(VEC_ZERO_B));
      queue_vector(len, kind);
    end
    drain_all();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: full-scale corners, sign extremes, zero norms, bit patterns.
    push_pair(16'h7FFF, 16'h7FFF, 1'b1);
    push_pair(16'h8000, 16'h8000, 1'b1);
    push_pair(16'h8000, 16'h7FFF, 1'b1);
    push_pair(16'h7FFF, 16'h8000, 1'b1);
    push_pair(16'h0001, 16'hFFFF, 1'b1);
    push_pair(16'h0000, 16'h0005, 1'b0);
    push_pair(16'h0000, 16'hFFF9, 1'b1);
    push_pair(16'h0003, 16'h0000, 1'b1);
    push_pair(16'h0000, 16'h0000, 1'b1);
    push_pair(16'h0001, 16'h0000, 1'b0);
    push_pair(16'h0000, 16'h0001, 1'b1);
    push_pair(16'h5555, 16'hAAAA, 1'b0);
    push_pair(16'hAAAA, 16'h5555, 1'b1);
    push_pair(16'h0003, 16'h0004, 1'b0);
    push_pair(16'hFFFE, 16'h0001, 1'b0);
    push_pair(16'h1234, 16'hEDCC, 1'b1);
    push_pair(16'hFFFF, 16'hFFFF, 1'b1);
    push_pair(16'h0002, 16'h0001, 1'b0);
    push_pair(16'h0001, 16'h0002, 1'b1);
    drain_all();

    random_phase(0, 0, 130);
    random_phase(69, 0, 130);
    random_phase(0, 69, 130);
    random_phase(35, 35, 130);

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d element pairs and %0d scores (%0d degenerate),",
             pairs_taken, scores_checked, degen_seen);
    $display("including full-scale corners, zero norms and four flow-control mixes");
    if (mismatch_count == 0 && expected_scores.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (expected_scores.size() != 0)
        $error("%0d expected results never arrived", expected_scores.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
